FILE: sv/tbss_pkg.sv
// Shared types, constants and helpers for the text buffer search and scroll block.
// Used by tbss_ctrl, tbss_dp, the top level and the port checker.
package tbss_pkg;

  // Storage sizes and derived widths
  localparam int TEXT_DEPTH  = 4096;
  localparam int TEXT_AW     = 12;
  localparam int LEN_W       = 13;
  localparam int LINE_DEPTH  = 1024;
  localparam int LINE_AW     = 10;
  localparam int LC_W        = 11;
  localparam int QUERY_DEPTH = 64;
  localparam int QUERY_AW    = 6;
  localparam int QLEN_W      = 7;
  localparam int QCNT_W      = 13;

  // Byte classes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PUNC_LO = 8'h2D;
  localparam logic [7:0] CH_PUNC_HI = 8'h3A;
  localparam logic [7:0] CH_UPPER_LO = 8'h41;
  localparam logic [7:0] CH_UPPER_HI = 8'h5A;

  typedef enum logic [2:0] {
    ACT_TEXT      = 3'd0,
    ACT_QUERY     = 3'd1,
    ACT_LINE_UP   = 3'd2,
    ACT_LINE_DOWN = 3'd3,
    ACT_PAGE_UP   = 3'd4,
    ACT_PAGE_DOWN = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_CAPACITY    = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } st_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STEP,
    OP_START,
    OP_NEXT_PASS,
    OP_CAND,
    OP_QNEXT,
    OP_POSNEXT,
    OP_HIT,
    OP_MISS,
    OP_LNEXT,
    OP_LDONE,
    OP_RESP
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_START2,
    S_CAND,
    S_RD,
    S_CMP,
    S_LRD,
    S_LCMP,
    S_RESP
  } state_e;

  typedef struct packed {
    dp_op_e op;
    logic   ls_use_k;
  } tbss_cmd_t;

  typedef struct packed {
    logic step_search;
    logic step_result;
    logic cand_ok;
    logic pass1_ok;
    logic cmp_eq;
    logic q_last;
    logic k_lt;
    logic ls_le;
    logic out_blocked;
  } tbss_sts_t;

  function automatic logic byte_ok(input logic [7:0] c);
    return (c == CH_NL) || (c == CH_SPACE) ||
           (c >= CH_PUNC_LO && c <= CH_PUNC_HI) ||
           (c >= CH_UPPER_LO && c <= CH_UPPER_HI);
  endfunction

endpackage

FILE: sv/tbss_ctrl.sv
// Controller state machine: sequences item steps, substring search and line lookup.
// Depends on tbss_pkg; drives tbss_dp through command and status structs.
module tbss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  tbss_pkg::tbss_sts_t sts_i,
  output tbss_pkg::tbss_cmd_t cmd_o,
  output logic               idle_o
);
  import tbss_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.ls_use_k = 1'b0;
    idle_o         = 1'b0;
    case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (accept_i) begin
          cmd_o.op = OP_STEP;
          if (sts_i.step_search) state_d = S_START;
          else if (sts_i.step_result) state_d = S_RESP;
        end
      end
      // line start of the top line is read here
      S_START: state_d = S_START2;
      S_START2: begin
        cmd_o.op = OP_START;
        state_d  = S_CAND;
      end
      S_CAND: begin
        if (sts_i.cand_ok) begin
          cmd_o.op = OP_CAND;
          state_d  = S_RD;
        end else if (sts_i.pass1_ok) begin
          cmd_o.op = OP_NEXT_PASS;
        end else begin
          cmd_o.op = OP_MISS;
          state_d  = S_RESP;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (!sts_i.cmp_eq) begin
          cmd_o.op = OP_POSNEXT;
          state_d  = S_CAND;
        end else if (sts_i.q_last) begin
          cmd_o.op = OP_HIT;
          state_d  = S_LRD;
        end else begin
          cmd_o.op = OP_QNEXT;
          state_d  = S_RD;
        end
      end
      S_LRD: begin
        cmd_o.ls_use_k = 1'b1;
        if (sts_i.k_lt) begin
          state_d = S_LCMP;
        end else begin
          cmd_o.op = OP_LDONE;
          state_d  = S_RESP;
        end
      end
      S_LCMP: begin
        cmd_o.ls_use_k = 1'b1;
        if (sts_i.ls_le) begin
          cmd_o.op = OP_LNEXT;
          state_d  = S_LRD;
        end else begin
          cmd_o.op = OP_LDONE;
          state_d  = S_RESP;
        end
      end
      S_RESP: begin
        cmd_o.op = OP_RESP;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: sv/tbss_dp.sv
// Datapath: text, line start and query memories, viewer state, search registers
// and the output register. Depends on tbss_pkg; commanded by tbss_ctrl.
module tbss_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbss_pkg::tbss_cmd_t cmd_i,
  output tbss_pkg::tbss_sts_t sts_o,
  input  logic [2:0]          action_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_item_i,
  input  logic [10:0]         page_rows_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [2:0]          status_o,
  output logic [9:0]          view_line_o,
  output logic [10:0]         line_total_o,
  output logic                match_valid_o,
  output logic [11:0]         match_position_o,
  output logic [6:0]          match_size_o
);
  import tbss_pkg::*;

  // Memories
  logic [7:0]         text_mem [TEXT_DEPTH];
  logic [TEXT_AW-1:0] ls_mem   [LINE_DEPTH];
  logic [7:0]         qry_mem  [QUERY_DEPTH];

  // Viewer state
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LC_W-1:0]    lc_q, lc_d;
  logic [LINE_AW-1:0] top_q, top_d;
  logic [TEXT_AW-1:0] off_q, off_d;
  logic [QLEN_W-1:0]  mlen_q, mlen_d;
  logic               match_q, match_d;
  logic               open_q, open_d;
  st_e                le_q, le_d;
  logic               pnl_q, pnl_d;
  logic [QCNT_W-1:0]  qcnt_q, qcnt_d;
  st_e                qerr_q, qerr_d;
  st_e                st_q, st_d;

  // Search and line scan registers
  logic [LEN_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   start_q, start_d;
  logic [LEN_W-1:0]   end_q, end_d;
  logic               pass_q, pass_d;
  logic [QLEN_W-1:0]  slen_q, slen_d;
  logic [QLEN_W-1:0]  q_q, q_d;
  logic [LC_W-1:0]    k_q, k_d;
  logic [LINE_AW-1:0] best_q, best_d;

  // Read data registers
  logic [7:0]         tx_rd_q, qs_rd_q;
  logic [TEXT_AW-1:0] ls_rd_q;

  // Output register
  logic               ov_q, ov_d;
  logic [2:0]         o_st_q;
  logic [9:0]         o_top_q;
  logic [10:0]        o_lt_q;
  logic               o_mv_q;
  logic [11:0]        o_mp_q;
  logic [6:0]         o_ms_q;

  // Write ports
  logic               tx_we, ls_we, qs_we;
  logic [TEXT_AW-1:0] tx_wa;
  logic [LINE_AW-1:0] ls_wa;
  logic [TEXT_AW-1:0] ls_wd;
  logic [QUERY_AW-1:0] qs_wa;

  act_e               act;
  logic               t_restart, t_nl;
  logic [LEN_W-1:0]   t_i;
  logic [LC_W-1:0]    t_lc, t_lc_n;
  st_e                t_le;
  st_e                q_err;
  logic [QCNT_W-1:0]  q_n;
  logic [LINE_AW-1:0] lastline, remaining;
  logic [LEN_W-1:0]   s_start;
  logic [LINE_AW-1:0] ls_ra;
  logic [TEXT_AW-1:0] tx_ra;

  assign act = act_e'(action_i);

  // Text byte: position, line count and load error after this byte
  always_comb begin
    t_restart = open_q || (len_q == '0);
    t_i       = t_restart ? '0 : len_q;
    t_lc      = t_restart ? LC_W'(1) : lc_q;
    t_le      = t_restart ? ST_OK : le_q;
    if (!byte_ok(data_byte_i)) t_le = ST_UNSUPPORTED;
    else if (t_i >= LEN_W'(TEXT_DEPTH) && t_le == ST_OK) t_le = ST_CAPACITY;
    t_nl   = !t_restart && pnl_q;
    t_lc_n = t_lc;
    if (t_nl) begin
      if (t_lc >= LC_W'(LINE_DEPTH) && t_le == ST_OK) t_le = ST_CAPACITY;
      if (t_lc <= LC_W'(LINE_DEPTH)) t_lc_n = t_lc + 1'b1;
    end
  end

  // Query byte: error and saturating length
  always_comb begin
    q_err = (qcnt_q == '0) ? ST_OK : qerr_q;
    if (data_byte_i == CH_NL || !byte_ok(data_byte_i)) q_err = ST_UNSUPPORTED;
    else if (qcnt_q >= QCNT_W'(QUERY_DEPTH) && q_err == ST_OK) q_err = ST_CAPACITY;
    q_n = (qcnt_q == '1) ? qcnt_q : qcnt_q + 1'b1;
  end

  assign lastline  = LINE_AW'(lc_q - 1'b1);
  assign remaining = lastline - top_q;
  assign s_start   = (match_q && {1'b0, off_q} < len_q) ? LEN_W'(off_q) + 1'b1
                                                        : LEN_W'(ls_rd_q);

  // Status toward the controller
  always_comb begin
    sts_o.step_search = (act == ACT_QUERY) && last_item_i && open_q &&
                        !(q_n > len_q) && (q_err == ST_OK);
    sts_o.step_result = !((act == ACT_TEXT || act == ACT_QUERY) && !last_item_i);
    sts_o.cand_ok     = ({1'b0, pos_q} + (LEN_W + 1)'(slen_q)) <= {1'b0, end_q};
    sts_o.pass1_ok    = !pass_q && (start_q != '0);
    sts_o.cmp_eq      = tx_rd_q == qs_rd_q;
    sts_o.q_last      = QLEN_W'(q_q + 1'b1) == slen_q;
    sts_o.k_lt        = k_q < lc_q;
    sts_o.ls_le       = {1'b0, ls_rd_q} <= pos_q;
    sts_o.out_blocked = ov_q && out_stall_i;
  end

  // Next state of all registers
  always_comb begin
    len_d = len_q; lc_d = lc_q; top_d = top_q; off_d = off_q; mlen_d = mlen_q;
    match_d = match_q; open_d = open_q; le_d = le_q; pnl_d = pnl_q;
    qcnt_d = qcnt_q; qerr_d = qerr_q; st_d = st_q;
    pos_d = pos_q; start_d = start_q; end_d = end_q; pass_d = pass_q;
    slen_d = slen_q; q_d = q_q; k_d = k_q; best_d = best_q;
    ov_d  = ov_q && out_stall_i;
    tx_we = 1'b0; tx_wa = t_i[TEXT_AW-1:0];
    ls_we = 1'b0; ls_wa = '0; ls_wd = '0;
    qs_we = 1'b0; qs_wa = qcnt_q[QUERY_AW-1:0];
    case (cmd_i.op)
      OP_STEP: begin
        case (act)
          ACT_TEXT: begin
            if (t_restart) begin
              top_d = '0; match_d = 1'b0; off_d = '0; mlen_d = '0;
              ls_we = 1'b1;
            end else if (t_nl && t_lc < LC_W'(LINE_DEPTH)) begin
              ls_we = 1'b1;
              ls_wa = t_lc[LINE_AW-1:0];
              ls_wd = t_i[TEXT_AW-1:0];
            end
            tx_we  = t_i < LEN_W'(TEXT_DEPTH);
            pnl_d  = (t_i < LEN_W'(TEXT_DEPTH)) && (data_byte_i == CH_NL);
            len_d  = (t_i <= LEN_W'(TEXT_DEPTH)) ? t_i + 1'b1 : t_i;
            lc_d   = t_lc_n;
            le_d   = t_le;
            open_d = 1'b0;
            if (last_item_i) begin
              if (t_le == ST_OK) begin
                open_d = 1'b1;
                st_d   = ST_OK;
              end else begin
                st_d  = t_le;
                len_d = '0;
                lc_d  = '0;
                le_d  = ST_OK;
              end
            end
          end
          ACT_QUERY: begin
            qs_we = qcnt_q < QCNT_W'(QUERY_DEPTH);
            if (last_item_i) begin
              qcnt_d = '0;
              qerr_d = ST_OK;
              slen_d = q_n[QLEN_W-1:0];
              if (!open_q || q_n > len_q) st_d = ST_INVALID;
              else st_d = q_err;
            end else begin
              qcnt_d = q_n;
              qerr_d = q_err;
            end
          end
          ACT_LINE_UP, ACT_LINE_DOWN, ACT_PAGE_UP, ACT_PAGE_DOWN: begin
            st_d = ST_INVALID;
            if (open_q) begin
              st_d = ST_OK;
              if (act == ACT_LINE_UP) begin
                if (top_q != '0) top_d = top_q - 1'b1;
              end else if (act == ACT_LINE_DOWN) begin
                if (top_q < lastline) top_d = top_q + 1'b1;
              end else if (page_rows_i == '0) begin
                st_d = ST_INVALID;
              end else if (act == ACT_PAGE_UP) begin
                top_d = ({1'b0, top_q} > page_rows_i) ?
                        LINE_AW'({1'b0, top_q} - page_rows_i) : '0;
              end else begin
                top_d = (page_rows_i < {1'b0, remaining}) ?
                        LINE_AW'({1'b0, top_q} + page_rows_i) : lastline;
              end
            end
          end
          default: st_d = ST_INVALID;
        endcase
      end
      OP_START: begin
        start_d = s_start;
        pos_d   = s_start;
        end_d   = len_q;
        pass_d  = 1'b0;
      end
      OP_NEXT_PASS: begin
        pass_d = 1'b1;
        pos_d  = '0;
        end_d  = match_q ? LEN_W'(off_q) : start_q;
      end
      OP_CAND:    q_d = '0;
      OP_QNEXT:   q_d = q_q + 1'b1;
      OP_POSNEXT: pos_d = pos_q + 1'b1;
      OP_HIT: begin
        off_d   = pos_q[TEXT_AW-1:0];
        mlen_d  = slen_q;
        match_d = 1'b1;
        k_d     = '0;
        best_d  = '0;
      end
      OP_MISS: st_d = ST_NOT_FOUND;
      OP_LNEXT: begin
        best_d = k_q[LINE_AW-1:0];
        k_d    = k_q + 1'b1;
      end
      OP_LDONE: begin
        top_d = best_q;
        st_d  = ST_OK;
      end
      OP_RESP: ov_d = 1'b1;
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; lc_q <= '0; top_q <= '0; off_q <= '0; mlen_q <= '0;
      match_q <= 1'b0; open_q <= 1'b0; le_q <= ST_OK; pnl_q <= 1'b0;
      qcnt_q <= '0; qerr_q <= ST_OK; st_q <= ST_OK;
      pos_q <= '0; start_q <= '0; end_q <= '0; pass_q <= 1'b0;
      slen_q <= '0; q_q <= '0; k_q <= '0; best_q <= '0;
      ov_q <= 1'b0;
    end else begin
      len_q <= len_d; lc_q <= lc_d; top_q <= top_d; off_q <= off_d; mlen_q <= mlen_d;
      match_q <= match_d; open_q <= open_d; le_q <= le_d; pnl_q <= pnl_d;
      qcnt_q <= qcnt_d; qerr_q <= qerr_d; st_q <= st_d;
      pos_q <= pos_d; start_q <= start_d; end_q <= end_d; pass_q <= pass_d;
      slen_q <= slen_d; q_q <= q_d; k_q <= k_d; best_q <= best_d;
      ov_q <= ov_d;
    end
  end

  // Output payload, loaded when a result is posted
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESP) begin
      o_st_q  <= st_q;
      o_top_q <= top_q;
      o_lt_q  <= open_q ? lc_q : '0;
      o_mv_q  <= match_q;
      o_mp_q  <= match_q ? off_q : '0;
      o_ms_q  <= match_q ? mlen_q : '0;
    end
  end

  // Memory ports: one write and one registered read each
  assign ls_ra = cmd_i.ls_use_k ? k_q[LINE_AW-1:0] : top_q;
  assign tx_ra = TEXT_AW'(pos_q + LEN_W'(q_q));

  always_ff @(posedge clk_i) begin
    if (tx_we) text_mem[tx_wa] <= data_byte_i;
    tx_rd_q <= text_mem[tx_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) ls_mem[ls_wa] <= ls_wd;
    ls_rd_q <= ls_mem[ls_ra];
  end

  always_ff @(posedge clk_i) begin
    if (qs_we) qry_mem[qs_wa] <= data_byte_i;
    qs_rd_q <= qry_mem[q_q[QUERY_AW-1:0]];
  end

  assign out_valid_o      = ov_q;
  assign status_o         = o_st_q;
  assign view_line_o      = o_top_q;
  assign line_total_o     = o_lt_q;
  assign match_valid_o    = o_mv_q;
  assign match_position_o = o_mp_q;
  assign match_size_o     = o_ms_q;

endmodule

FILE: sv/text_buffer_search_and_scroll.sv
// Top level of the text buffer search and scroll block.
// Depends on tbss_pkg, tbss_ctrl and tbss_dp.
//
// Input channel (in_valid_i / in_stall_o) carries one action per transfer:
// text bytes, query bytes, line up/down and page up/down. Output channel
// (out_valid_o / out_stall_i) carries one result per transfer.
// Non-final text and query bytes give no result; they are taken one per cycle while no result waits.
// Every other action posts its result through the response state into the output
// register, and the input can take the next item in the cycle the result appears.
// A final query byte starts a search: setup in S_START and S_START2, then per candidate
// position a fit check in S_CAND and a read and compare (S_RD, S_CMP) per query byte,
// a switch to the wrapped pass in S_CAND, then a read and compare (S_LRD, S_LCMP) per
// line start walked to find the line of the hit, and S_RESP to post the result. The
// text and line start memories have registered reads; input is stalled meanwhile.
// Reset clears all viewer state: no text open, top line 0, no match. Memory
// contents are not cleared and need no clearing pass.
// While the receiver stalls, the result is held in the output register and
// the input is stalled as long as that result waits.
module text_buffer_search_and_scroll (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_item_i,
  input  logic [10:0] page_rows_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  view_line_o,
  output logic [10:0] line_total_o,
  output logic        match_valid_o,
  output logic [11:0] match_position_o,
  output logic [6:0]  match_size_o
);
  import tbss_pkg::*;

  tbss_cmd_t cmd;
  tbss_sts_t sts;
  logic      idle;
  logic      accept;

  // Take an item only in idle and when the output register can drain
  assign in_stall_o = !idle || sts.out_blocked;
  assign accept     = in_valid_i && !in_stall_o;

  tbss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .idle_o   (idle)
  );

  tbss_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .data_byte_i      (data_byte_i),
    .last_item_i      (last_item_i),
    .page_rows_i      (page_rows_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .view_line_o      (view_line_o),
    .line_total_o     (line_total_o),
    .match_valid_o    (match_valid_o),
    .match_position_o (match_position_o),
    .match_size_o     (match_size_o)
  );

endmodule

FILE: sv/tbss_chk.sv
// Port-level checker for the text buffer search and scroll block.
// Depends on tbss_pkg; attached to the top level by the bind below.
module tbss_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [2:0]  action_i,
  input logic [7:0]  data_byte_i,
  input logic        last_item_i,
  input logic [10:0] page_rows_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [9:0]  view_line_o,
  input logic [10:0] line_total_o,
  input logic        match_valid_o,
  input logic [11:0] match_position_o,
  input logic [6:0]  match_size_o
);
  import tbss_pkg::*;

  // A stalled result holds until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(view_line_o) && $stable(match_position_o))
    else $error("stalled result changed");

  // No match means zero position and size
  a_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_valid_o |-> match_position_o == '0 && match_size_o == '0)
    else $error("match fields without a match");

  // Without an open text there is no match and the view is at line 0
  a_notext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_total_o == '0 |-> !match_valid_o && view_line_o == '0)
    else $error("view state without open text");

  // Top line stays inside the text
  a_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_total_o != '0 |-> {1'b0, view_line_o} < line_total_o)
    else $error("top line beyond last line");

  // Status is a known code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'(ST_NOT_FOUND))
    else $error("unknown status code");

endmodule

bind text_buffer_search_and_scroll tbss_chk u_tbss_chk (.*);

FILE: bench/text_buffer_search_and_scroll_tb.sv
// Testbench for text_buffer_search_and_scroll: directed and random text loads,
// queries and scrolls, checked against a behavioral viewer model kept in the bench.
// Depends on tbss_pkg and the text_buffer_search_and_scroll RTL.
module text_buffer_search_and_scroll_tb;
  import tbss_pkg::*;

  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam int         RAND_ITEMS  = 1250;
  localparam int         CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [2:0]  status;
    logic [9:0]  top;
    logic [10:0] total;
    logic        mvalid;
    logic [11:0] mpos;
    logic [6:0]  msize;
  } view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [7:0]  data_byte = '0;
  logic        last_item = 1'b0;
  logic [10:0] page_rows = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [9:0]  view_line;
  logic [10:0] line_total;
  logic        match_valid;
  logic [11:0] match_position;
  logic [6:0]  match_size;

  view_t pending_views[$];
  int    err_cnt = 0;
  int    item_cnt = 0;
  int    cyc = 0;
  bit    steady = 1'b0;

  // Viewer state mirror
  logic [7:0]  txt_mem [TEXT_DEPTH];
  int unsigned ln_mem [LINE_DEPTH];
  logic [7:0]  qry_mem [QUERY_DEPTH];
  int unsigned txt_len = 0, ln_cnt = 0, top_ln = 0, m_off = 0, m_len = 0;
  bit          m_flag = 0, txt_open = 0;
  int unsigned ld_err = 0, q_len = 0, q_err = 0;

  text_buffer_search_and_scroll i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .data_byte_i      (data_byte),
    .last_item_i      (last_item),
    .page_rows_i      (page_rows),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .view_line_o      (view_line),
    .line_total_o     (line_total),
    .match_valid_o    (match_valid),
    .match_position_o (match_position),
    .match_size_o     (match_size)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic bit char_allowed(logic [7:0] c);
    return c == CH_NL || c == CH_SPACE || (c >= CH_PUNC_LO && c <= CH_PUNC_HI) ||
           (c >= CH_UPPER_LO && c <= CH_UPPER_HI);
  endfunction

  function automatic int unsigned line_holding(int unsigned off);
    int unsigned best;
    best = 0;
    for (int unsigned k = 0; k < ln_cnt && k < LINE_DEPTH; k++)
      if (ln_mem[k] <= off) best = k;
    return best;
  endfunction

  // Forward scan from the current spot, then one wrap to the part before it
  function automatic logic [2:0] find_query(int unsigned qlen);
    int unsigned start, from, upto, p;
    bit hit;
    if (m_flag && m_off < txt_len) start = m_off + 1;
    else start = (top_ln < LINE_DEPTH) ? ln_mem[top_ln] : 0;
    for (int pass = 0; pass < 2; pass++) begin
      from = (pass == 0) ? start : 0;
      if (pass == 0) upto = txt_len;
      else upto = m_flag ? m_off : start;
      if (upto >= qlen) begin
        for (int unsigned i = from; i <= upto - qlen; i++) begin
          hit = 1'b1;
          for (int unsigned q = 0; q < qlen && hit; q++) begin
            p = i + q;
            if (p >= TEXT_DEPTH || q >= QUERY_DEPTH) hit = 1'b0;
            else if (txt_mem[p] !== qry_mem[q]) hit = 1'b0;
          end
          if (hit) begin
            m_off = i;
            m_len = qlen;
            m_flag = 1'b1;
            top_ln = line_holding(i);
            return ST_OK;
          end
        end
      end
      if (start == 0) break;
    end
    return ST_NOT_FOUND;
  endfunction

  // Returns 1 when the item produces a result, filled into r
  function automatic bit viewer_step(logic [2:0] act, logic [7:0] b, bit last,
                                     logic [10:0] rows, output view_t r);
    logic [2:0] st;
    int unsigned i, qlen, err, lastline, remaining;
    st = ST_INVALID;
    if (act == ACT_TEXT) begin
      if (txt_open || txt_len == 0) begin
        txt_open = 0; txt_len = 0; ln_cnt = 1; ln_mem[0] = 0; top_ln = 0;
        m_flag = 0; m_off = 0; m_len = 0; ld_err = 0;
      end
      i = txt_len;
      if (!char_allowed(b)) ld_err = ST_UNSUPPORTED;
      else if (i >= TEXT_DEPTH && ld_err == 0) ld_err = ST_CAPACITY;
      if (i < TEXT_DEPTH) txt_mem[i] = b;
      if (i > 0 && i - 1 < TEXT_DEPTH && txt_mem[i-1] == CH_NL) begin
        if (ln_cnt < LINE_DEPTH) ln_mem[ln_cnt] = i;
        else if (ld_err == 0) ld_err = ST_CAPACITY;
        if (ln_cnt <= LINE_DEPTH) ln_cnt++;
      end
      if (txt_len <= TEXT_DEPTH) txt_len++;
      if (!last) return 1'b0;
      if (ld_err == 0) begin
        txt_open = 1;
        st = ST_OK;
      end else begin
        st = ld_err[2:0];
        txt_len = 0; ln_cnt = 0; ld_err = 0; txt_open = 0;
      end
    end else if (act == ACT_QUERY) begin
      i = q_len;
      if (i == 0) q_err = 0;
      if (b == CH_NL || !char_allowed(b)) q_err = ST_UNSUPPORTED;
      else if (i >= QUERY_DEPTH && q_err == 0) q_err = ST_CAPACITY;
      if (i < QUERY_DEPTH) qry_mem[i] = b;
      q_len++;
      if (!last) return 1'b0;
      qlen = q_len;
      err = q_err;
      q_len = 0;
      q_err = 0;
      if (!txt_open || qlen > txt_len) st = ST_INVALID;
      else if (err != 0) st = err[2:0];
      else st = find_query(qlen);
    end else if (act <= ACT_PAGE_DOWN && txt_open) begin
      lastline = ln_cnt - 1;
      st = ST_OK;
      if (act == ACT_LINE_UP) begin
        if (top_ln != 0) top_ln--;
      end else if (act == ACT_LINE_DOWN) begin
        if (top_ln < lastline) top_ln++;
      end else if (rows == 0) begin
        st = ST_INVALID;
      end else if (act == ACT_PAGE_UP) begin
        top_ln = (top_ln > rows) ? top_ln - rows : 0;
      end else begin
        remaining = lastline - top_ln;
        top_ln = (rows < remaining) ? top_ln + rows : lastline;
      end
    end
    r.status = st;
    r.top    = top_ln[9:0];
    r.total  = txt_open ? ln_cnt[10:0] : 11'd0;
    r.mvalid = m_flag;
    r.mpos   = m_flag ? m_off[11:0] : 12'd0;
    r.msize  = m_flag ? m_len[6:0] : 7'd0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cyc, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    view_t e;
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        report("result transfer with nothing pending");
      end else begin
        e = pending_views.pop_front();
        if (status !== e.status)
          report($sformatf("status %0d, want %0d", status, e.status));
        if (view_line !== e.top)
          report($sformatf("view_line %0d, want %0d", view_line, e.top));
        if (line_total !== e.total)
          report($sformatf("line_total %0d, want %0d", line_total, e.total));
        if (match_valid !== e.mvalid)
          report($sformatf("match_valid %0d, want %0d", match_valid, e.mvalid));
        if (match_position !== e.mpos)
          report($sformatf("match_position %0d, want %0d", match_position, e.mpos));
        if (match_size !== e.msize)
          report($sformatf("match_size %0d, want %0d", match_size, e.msize));
      end
    end
  end

  // Receiver backpressure: stall bursts, mostly short, some long, some none
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, 99);
      if (steady || n < 40) n = 0;
      else if (n < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [10:0] pick_rows();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 11'd0;
    if (r < 16) return 11'($urandom_range(0, 2047));
    if (r < 22) return 11'd1024;
    return 11'($urandom_range(1, 8));
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CH_NL;
    if (r < 22) return CH_SPACE;
    if (r < 40) return 8'($urandom_range(CH_PUNC_LO, CH_PUNC_HI));
    if (r < 75) return 8'($urandom_range(CH_UPPER_LO, CH_UPPER_LO + 1));
    return 8'($urandom_range(CH_UPPER_LO, CH_UPPER_HI));
  endfunction

  function automatic logic [10:0] any_rows();
    return 11'($urandom_range(0, 2047));
  endfunction

  // One input transfer; the model is stepped on acceptance
  task automatic send_item(input logic [2:0] act, input logic [7:0] b, input bit last,
                           input logic [10:0] rows);
    int    g;
    view_t r;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    last_item <= last;
    page_rows <= rows;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (viewer_step(act, b, last, rows, r)) pending_views.push_back(r);
    item_cnt++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++)
      send_item(ACT_TEXT, s[k], k == s.len() - 1, any_rows());
  endtask

  task automatic send_query(input string s);
    for (int k = 0; k < s.len(); k++)
      send_item(ACT_QUERY, s[k], k == s.len() - 1, any_rows());
  endtask

  // Text of n bytes, a newline every `every` bytes, one marker byte at mark_at
  task automatic send_pattern(input int n, input int every, input int mark_at,
                              input logic [7:0] mark);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      b = ((k % every) == every - 1) ? CH_NL : 8'(CH_UPPER_LO + (k % 3));
      if (k == mark_at) b = mark;
      send_item(ACT_TEXT, b, k == n - 1, 11'd0);
    end
  endtask

  task automatic query_from_text();
    int len, pos;
    if (!txt_open || txt_len == 0) begin
      send_query("AB");
    end else begin
      len = $urandom_range(1, (txt_len < 6) ? txt_len : 6);
      pos = $urandom_range(0, txt_len - len);
      for (int k = 0; k < len; k++)
        send_item(ACT_QUERY, txt_mem[pos + k], k == len - 1, any_rows());
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_no_text();
    send_item(ACT_LINE_UP, 8'h00, 1'b0, 11'd1);
    send_item(ACT_LINE_DOWN, 8'hFF, 1'b1, 11'd2047);
    send_item(ACT_PAGE_UP, 8'h41, 1'b0, 11'd5);
    send_item(ACT_PAGE_DOWN, 8'h41, 1'b1, 11'd0);
    send_item(ACT_SPARE_A, 8'h41, 1'b1, 11'd1);
    send_query("A");
    wait_results();
  endtask

  task automatic test_scroll_and_find();
    send_text("AB\nB-A AB\n\n:9 Z\nAB");
    send_item(ACT_LINE_UP, 8'h00, 1'b0, 11'd0);
    repeat (6) send_item(ACT_LINE_DOWN, 8'h00, 1'b0, 11'd0);
    send_item(ACT_PAGE_UP, 8'h00, 1'b0, 11'd0);
    send_item(ACT_PAGE_UP, 8'h00, 1'b0, 11'd2);
    send_item(ACT_PAGE_DOWN, 8'h00, 1'b0, 11'd1024);
    send_item(ACT_PAGE_UP, 8'h00, 1'b0, 11'd2047);
    send_item(ACT_SPARE_B, 8'h00, 1'b0, 11'd3);
    repeat (4) send_query("AB");
    send_query("QQ");
    send_query("A\n");
    send_query({"A", 8'h7F});
    send_query("ABABABABABABABABABABABAB");
    wait_results();
  endtask

  task automatic test_long_query();
    string s;
    s = "";
    for (int k = 0; k < 16; k++) s = {s, "ABCDE"};
    send_text(s);
    send_query(s.substr(0, 63));
    send_query(s.substr(0, 64));
    for (int k = 0; k <= 65; k++)
      send_item(ACT_QUERY, s[k], 1'b0, any_rows());
    send_item(ACT_QUERY, 8'h00, 1'b1, any_rows());
    wait_results();
  endtask

  task automatic test_load_errors();
    send_item(ACT_TEXT, "A", 1'b0, 11'd0);
    send_item(ACT_TEXT, "B", 1'b0, 11'd0);
    send_item(ACT_TEXT, 8'h00, 1'b1, 11'd0);
    send_item(ACT_LINE_DOWN, 8'h00, 1'b0, 11'd0);
    send_text({"A", 8'hFF, "B"});
    send_query("A");
    // load, query and scroll interleaved
    send_item(ACT_TEXT, "A", 1'b0, 11'd0);
    send_item(ACT_QUERY, "B", 1'b0, 11'd0);
    send_item(ACT_TEXT, "B", 1'b0, 11'd0);
    send_item(ACT_PAGE_DOWN, 8'h00, 1'b0, 11'd1);
    send_item(ACT_TEXT, "\n", 1'b1, 11'd0);
    send_item(ACT_QUERY, "\n", 1'b1, 11'd0);
    send_query("B");
    wait_results();
  endtask

  task automatic test_capacity();
    steady = 1'b1;
    send_pattern(TEXT_DEPTH, 4, TEXT_DEPTH - 2, "Z");
    send_item(ACT_PAGE_DOWN, 8'h00, 1'b0, 11'd1024);
    send_item(ACT_PAGE_UP, 8'h00, 1'b0, 11'd1);
    send_query("Z");
    send_query("Z\n");
    wait_results();
    send_pattern(TEXT_DEPTH + 1, 4, -1, 8'h00);
    send_pattern(TEXT_DEPTH + 1, 4, 100, 8'h01);
    send_pattern(LINE_DEPTH, 1, LINE_DEPTH - 1, "A");
    send_pattern(LINE_DEPTH + 1, 1, LINE_DEPTH, "A");
    send_item(ACT_LINE_UP, 8'h00, 1'b0, 11'd0);
    steady = 1'b0;
    wait_results();
  endtask

  task automatic test_random();
    int start_cnt, r, n;
    start_cnt = item_cnt;
    send_text("AB\nBA");
    while (item_cnt - start_cnt < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 18) begin
        n = $urandom_range(1, 30);
        if ($urandom_range(0, 49) == 0) n = $urandom_range(200, 600);
        for (int k = 0; k < n; k++)
          send_item(ACT_TEXT, ($urandom_range(0, 199) == 0) ? 8'($urandom) : pick_char(),
                    k == n - 1, any_rows());
      end else if (r < 48) begin
        query_from_text();
      end else if (r < 56) begin
        n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
          send_item(ACT_QUERY, ($urandom_range(0, 19) == 0) ? 8'($urandom) : pick_char(),
                    k == n - 1, any_rows());
      end else if (r < 88) begin
        send_item(3'($urandom_range(ACT_LINE_UP, ACT_PAGE_DOWN)), 8'($urandom),
                  1'($urandom_range(0, 1)), pick_rows());
      end else if (r < 95) begin
        send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                  any_rows());
      end else if (r < 97) begin
        wait_results();
      end else begin
        steady = ~steady;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_text();
    test_scroll_and_find();
    test_long_query();
    test_load_errors();
    test_capacity();
    test_random();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: text_buffer_search_and_scroll.f
sv/tbss_pkg.sv
sv/tbss_ctrl.sv
sv/tbss_dp.sv
sv/text_buffer_search_and_scroll.sv
sv/tbss_chk.sv
bench/text_buffer_search_and_scroll_tb.sv
